@@ sv/brute_force_candidate_generator_macros.svh @@
// Assertion macros used by the candidate generator checker.
`ifndef BRUTE_FORCE_CANDIDATE_GENERATOR_MACROS_SVH
`define BRUTE_FORCE_CANDIDATE_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BFCG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BFCG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bfcg_pkg.sv @@
// Shared constants, codes and types of the candidate generator.
package bfcg_pkg;

  localparam int IDX_W      = 48;
  localparam int DICT_DEPTH = 256;
  localparam int DICT_AW    = $clog2(DICT_DEPTH);
  localparam int SYM_W      = 8;
  localparam int RADIX_W    = 9;
  localparam int POS_W      = 6;
  localparam int CNT_W      = $clog2(IDX_W);
  localparam int CFG_AW     = 2;

  localparam logic [0:0] REQ_WRITE = 1'b0;
  localparam logic [0:0] REQ_EMIT  = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_INDEX_LIMIT  = 2'd1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_EMIT
  } state_t;

endpackage

@@ sv/bfcg_in_if.sv @@
// Request channel: dictionary writes and candidate requests.
interface bfcg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bfcg_pkg::DICT_AW-1:0]  dict_slot;
  logic [bfcg_pkg::SYM_W-1:0]    dict_symbol;

  modport source (output valid, req_type, dict_slot, dict_symbol, input ready);
  modport sink   (input valid, req_type, dict_slot, dict_symbol, output ready);
endinterface

@@ sv/bfcg_out_if.sv @@
// Result channel: one beat per candidate symbol or one done beat.
interface bfcg_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfcg_pkg::SYM_W-1:0]    symbol;
  logic [bfcg_pkg::DICT_AW-1:0]  symbol_index;
  logic [bfcg_pkg::POS_W-1:0]    position;
  logic                          last;
  logic                          done_res;

  modport source (output valid, symbol, symbol_index, position, last, done_res,
                  input ready);
  modport sink   (input valid, symbol, symbol_index, position, last, done_res,
                  output ready);
endinterface

@@ sv/bfcg_cfg_if.sv @@
// Configuration write channel.
interface bfcg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bfcg_pkg::CFG_AW-1:0]   addr;
  logic [bfcg_pkg::IDX_W-1:0]    data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ sv/bfcg_dict_mem.sv @@
// Dictionary memory: one write port, one registered read port.
module bfcg_dict_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [bfcg_pkg::DICT_AW-1:0]  wr_addr,
  input  logic [bfcg_pkg::SYM_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  logic [bfcg_pkg::DICT_AW-1:0]  rd_addr,
  output logic [bfcg_pkg::SYM_W-1:0]    rd_data
);

  logic [bfcg_pkg::SYM_W-1:0] mem [bfcg_pkg::DICT_DEPTH];
  logic [bfcg_pkg::SYM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/bfcg_div.sv @@
// Restoring divider: index value by radix, one quotient bit per cycle.
module bfcg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bfcg_pkg::IDX_W-1:0]    dividend,
  input  logic [bfcg_pkg::RADIX_W-1:0]  divisor,
  output logic                          done,
  output logic [bfcg_pkg::IDX_W-1:0]    quotient,
  output logic [bfcg_pkg::RADIX_W-1:0]  remainder
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [bfcg_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [bfcg_pkg::IDX_W-1:0]    quo_r, quo_nxt;
  logic [bfcg_pkg::RADIX_W-1:0]  rem_r, rem_nxt;
  logic [bfcg_pkg::RADIX_W-1:0]  dvs_r, dvs_nxt;
  logic [bfcg_pkg::RADIX_W:0]    shifted;
  logic [bfcg_pkg::RADIX_W:0]    trial;

  assign shifted = {rem_r, quo_r[bfcg_pkg::IDX_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // subtract when the shifted remainder covers the divisor
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = trial[bfcg_pkg::RADIX_W-1:0];
        quo_nxt = {quo_r[bfcg_pkg::IDX_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[bfcg_pkg::RADIX_W-1:0];
        quo_nxt = {quo_r[bfcg_pkg::IDX_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bfcg_pkg::CNT_W'(bfcg_pkg::IDX_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ sv/brute_force_candidate_generator.sv @@
// Candidate generator top level: expands the running index into dictionary symbols.
// Each symbol passes through the divider (S_DIV), the dictionary read (S_READ) and
// the output beat (S_EMIT), which may stall on the sink; the next request is taken
// in the cycle after the last beat. A dictionary write produces no result beat and
// a done result a single beat; one request at a time.
// Synchronous active-low reset: index 1, radix 2, limit 1; dictionary is not cleared.
module brute_force_candidate_generator (
  input  logic  clk,
  input  logic  rst_n,
  bfcg_in_if.sink    in_ch,
  bfcg_out_if.source out_ch,
  bfcg_cfg_if.sink   cfg_ch
);

  bfcg_pkg::state_t state_r, state_nxt;

  logic [bfcg_pkg::IDX_W-1:0]    next_index_r, next_index_nxt;
  logic [bfcg_pkg::IDX_W-1:0]    index_limit_r;
  logic [bfcg_pkg::RADIX_W-1:0]  symbol_count_r;
  logic [bfcg_pkg::IDX_W-1:0]    val_r, val_nxt;
  logic [bfcg_pkg::DICT_AW-1:0]  digit_r, digit_nxt;
  logic [bfcg_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [bfcg_pkg::SYM_W-1:0]    sym_r, sym_nxt;
  logic                          last_r, last_nxt;
  logic                          done_r, done_nxt;

  logic [bfcg_pkg::RADIX_W-1:0]  radix;
  logic [bfcg_pkg::RADIX_W-1:0]  digit_full;
  logic                          div_start;
  logic [bfcg_pkg::IDX_W-1:0]    div_dividend;
  logic                          div_done;
  logic [bfcg_pkg::IDX_W-1:0]    div_quo;
  logic [bfcg_pkg::RADIX_W-1:0]  div_rem;
  logic                          mem_wr_en;
  logic                          mem_rd_en;
  logic [bfcg_pkg::SYM_W-1:0]    mem_rd_data;
  logic                          in_fire;
  logic                          out_fire;

  // clamp the radix into the dictionary range
  always_comb begin
    if (symbol_count_r < bfcg_pkg::RADIX_W'(2)) begin
      radix = bfcg_pkg::RADIX_W'(2);
    end else if (symbol_count_r > bfcg_pkg::RADIX_W'(bfcg_pkg::DICT_DEPTH)) begin
      radix = bfcg_pkg::RADIX_W'(bfcg_pkg::DICT_DEPTH);
    end else begin
      radix = symbol_count_r;
    end
  end

  // (v-1) mod n from v mod n
  assign digit_full = (div_rem == '0) ? (radix - 1'b1) : (div_rem - 1'b1);

  assign in_ch.ready  = (state_r == bfcg_pkg::S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state_r == bfcg_pkg::S_EMIT);
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign mem_wr_en    = in_fire && (in_ch.req_type == bfcg_pkg::REQ_WRITE);
  assign div_dividend = (state_r == bfcg_pkg::S_IDLE) ? next_index_r : val_r;

  always_comb begin
    state_nxt      = state_r;
    next_index_nxt = next_index_r;
    val_nxt        = val_r;
    digit_nxt      = digit_r;
    pos_nxt        = pos_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    done_nxt       = done_r;
    div_start      = 1'b0;
    mem_rd_en      = 1'b0;
    case (state_r)
      bfcg_pkg::S_IDLE: begin
        if (in_fire && (in_ch.req_type == bfcg_pkg::REQ_EMIT)) begin
          pos_nxt = '0;
          if (next_index_r >= index_limit_r) begin
            done_nxt  = 1'b1;
            sym_nxt   = '0;
            digit_nxt = '0;
            last_nxt  = 1'b0;
            state_nxt = bfcg_pkg::S_EMIT;
          end else begin
            done_nxt  = 1'b0;
            div_start = 1'b1;
            state_nxt = bfcg_pkg::S_DIV;
          end
        end
      end
      bfcg_pkg::S_DIV: begin
        if (div_done) begin
          mem_rd_en = 1'b1;
          digit_nxt = digit_full[bfcg_pkg::DICT_AW-1:0];
          val_nxt   = div_quo;
          state_nxt = bfcg_pkg::S_READ;
        end
      end
      bfcg_pkg::S_READ: begin
        sym_nxt   = mem_rd_data;
        last_nxt  = (val_r == '0);
        state_nxt = bfcg_pkg::S_EMIT;
      end
      bfcg_pkg::S_EMIT: begin
        if (out_fire) begin
          if (done_r) begin
            state_nxt = bfcg_pkg::S_IDLE;
          end else if (last_r) begin
            next_index_nxt = next_index_r + 1'b1;
            state_nxt      = bfcg_pkg::S_IDLE;
          end else begin
            // advance to the next symbol of the candidate
            pos_nxt   = pos_r + 1'b1;
            div_start = 1'b1;
            state_nxt = bfcg_pkg::S_DIV;
          end
        end
      end
      default: begin
        state_nxt = bfcg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= bfcg_pkg::S_IDLE;
      next_index_r   <= bfcg_pkg::IDX_W'(1);
      symbol_count_r <= bfcg_pkg::RADIX_W'(2);
      index_limit_r  <= bfcg_pkg::IDX_W'(1);
      done_r         <= 1'b0;
      last_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_index_r <= next_index_nxt;
      done_r       <= done_nxt;
      last_r       <= last_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          bfcg_pkg::CFG_SYMBOL_COUNT: symbol_count_r <= cfg_ch.data[bfcg_pkg::RADIX_W-1:0];
          bfcg_pkg::CFG_INDEX_LIMIT:  index_limit_r  <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    digit_r <= digit_nxt;
    pos_r   <= pos_nxt;
    sym_r   <= sym_nxt;
  end

  assign out_ch.symbol       = sym_r;
  assign out_ch.symbol_index = digit_r;
  assign out_ch.position     = pos_r;
  assign out_ch.last         = last_r;
  assign out_ch.done_res     = done_r;

  bfcg_dict_mem u_dict (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (in_ch.dict_slot),
    .wr_data (in_ch.dict_symbol),
    .rd_en   (mem_rd_en),
    .rd_addr (digit_full[bfcg_pkg::DICT_AW-1:0]),
    .rd_data (mem_rd_data)
  );

  bfcg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

endmodule

@@ sv/bfcg_chk.sv @@
// Port-level checker for the candidate generator, bound to the top level.
`include "brute_force_candidate_generator_macros.svh"

module bfcg_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [bfcg_pkg::SYM_W-1:0]    out_symbol,
  input  logic [bfcg_pkg::DICT_AW-1:0]  out_symbol_index,
  input  logic [bfcg_pkg::POS_W-1:0]    out_position,
  input  logic                          out_last,
  input  logic                          out_done_res
);

  `BFCG_ASSERT_IMP(a_done_clean, out_valid && out_done_res, (out_symbol == '0) && (out_symbol_index == '0) && (out_position == '0) && !out_last, "done beat carries nonzero fields")
  `BFCG_ASSERT_IMP(a_pos_range, out_valid, out_position < bfcg_pkg::POS_W'(bfcg_pkg::IDX_W), "symbol position beyond index width")
  `BFCG_ASSERT_IMP(a_one_at_a_time, out_valid, !in_ready, "request taken while a result beat is pending")
  `BFCG_ASSERT_NXT(a_hold_valid, out_valid && !out_ready, out_valid, "result beat dropped under stall")

endmodule

bind brute_force_candidate_generator bfcg_chk u_bfcg_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_symbol       (out_ch.symbol),
  .out_symbol_index (out_ch.symbol_index),
  .out_position     (out_ch.position),
  .out_last         (out_ch.last),
  .out_done_res     (out_ch.done_res)
);
